### hdl/rmd_pkg.sv
package rmd_pkg;

    // Field and register widths
    localparam int CFG_W  = 12;
    localparam int CH_W   = 8;
    localparam int SUM_W  = CH_W + 1;
    localparam int NUM_CH = 4;

    // Reset value of both size registers
    localparam logic [CFG_W-1:0] CFG_RESET = 12'd2048;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_HALF_WIDTH  = 1'b0,
        REG_HALF_HEIGHT = 1'b1
    } t_reg_idx;

    // One source pixel, byte 0 in the low lane
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pix_bytes;

    // Four horizontal pair sums, one line store entry
    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_pair_sums;

    // One mip pixel as it leaves the block
    typedef struct packed {
        logic                         final_pixel;
        logic [NUM_CH-1:0][CH_W-1:0]  mip;
    } t_mip_pix;

endpackage

### hdl/rgba_mip_downsample_2x2_unit.sv
// 2x2 box-filter mip level generator for an RGBA8 pixel stream.
// Input channel (i_valid / o_ready): source pixels in raster order, one per
// request, bytes on i_chan_r/g/b/a. The image is 2*half_width by
// 2*half_height pixels; a size of zero acts as one, a size above the maximum
// acts as the maximum.
// Output channel (o_valid / i_ready): one mip pixel for each pixel pair of
// every odd source row, averages truncated; o_final_pixel marks the last one.
// Configuration: i_cfg_we writes register i_cfg_idx (0 half_width,
// 1 half_height) and restarts the image; write only while the block is idle.
// Throughput: one source pixel per cycle while o_ready is high. Even rows write
// their pair sums to the line store, odd rows read them back, so the single
// store sees at most one access per cycle and never a read and write of one
// entry close together.
// Path: the request that completes a block passes the line store read, then
// the output buffer, before its mip pixel is presented.
// Reset clears counters and the output buffer; sizes return to 2048 and the
// line store keeps its contents, which need no clearing pass.
// Stall: a two-entry output buffer absorbs results; o_ready is low in reset and
// otherwise drops only when that buffer and the result in flight would fill it.
module rgba_mip_downsample_2x2_unit
    import rmd_pkg::*;
#(
    parameter int MAX_HALF_WIDTH  = 2048,
    parameter int MAX_HALF_HEIGHT = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CH_W-1:0]   i_chan_r,
    input  logic [CH_W-1:0]   i_chan_g,
    input  logic [CH_W-1:0]   i_chan_b,
    input  logic [CH_W-1:0]   i_chan_a,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CH_W-1:0]   o_mip_r,
    output logic [CH_W-1:0]   o_mip_g,
    output logic [CH_W-1:0]   o_mip_b,
    output logic [CH_W-1:0]   o_mip_a,
    output logic              o_final_pixel
);

    localparam int CNT_W = $clog2(2 * MAX_HALF_WIDTH);
    localparam int ROW_W = $clog2(2 * MAX_HALF_HEIGHT);
    localparam int AW    = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
    localparam int XW_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int XW_H  = (ROW_W > CFG_W) ? ROW_W : CFG_W;
    localparam logic [XW_W-1:0] MAX_W = XW_W'(MAX_HALF_WIDTH);
    localparam logic [XW_H-1:0] MAX_H = XW_H'(MAX_HALF_HEIGHT);

    logic [CFG_W-1:0]  r_half_width;
    logic [CFG_W-1:0]  r_half_height;
    logic [CNT_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    t_pix_bytes        r_left;
    logic              r_s1_vld;
    t_pair_sums        r_s1_sums;
    logic              r_s1_final;

    logic [XW_W-1:0]   hw_ext;
    logic [XW_W-1:0]   hw_m1;
    logic [XW_H-1:0]   hh_ext;
    logic [XW_H-1:0]   hh_m1;
    logic [CNT_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;
    logic              col_end;
    logic              row_end;
    logic              in_acc;
    t_pix_bytes        cur_pix;
    t_pair_sums        cur_sums;
    logic [AW-1:0]     slot;
    logic              mem_wr;
    logic              mem_rd;
    t_pair_sums        prev_sums;
    t_mip_pix          res_pix;
    t_mip_pix          out_pix;
    logic [1:0]        buf_level;
    logic [2:0]        occupancy;
    logic [SUM_W:0]    blk_sum [NUM_CH];

    // Clamp sizes and derive the last column and row
    always_comb begin
        hw_ext = XW_W'(r_half_width);
        hh_ext = XW_H'(r_half_height);
        if (hw_ext == '0) begin
            hw_m1 = '0;
        end else if (hw_ext > MAX_W) begin
            hw_m1 = MAX_W - XW_W'(1);
        end else begin
            hw_m1 = hw_ext - XW_W'(1);
        end
        if (hh_ext == '0) begin
            hh_m1 = '0;
        end else if (hh_ext > MAX_H) begin
            hh_m1 = MAX_H - XW_H'(1);
        end else begin
            hh_m1 = hh_ext - XW_H'(1);
        end
    end

    assign last_col = CNT_W'({hw_m1, 1'b1});
    assign last_row = ROW_W'({hh_m1, 1'b1});
    assign col_end  = (r_col >= last_col);
    assign row_end  = (r_row >= last_row);

    assign in_acc  = i_valid && o_ready;
    assign cur_pix = {i_chan_a, i_chan_b, i_chan_g, i_chan_r};

    // Horizontal pair sums of the held even pixel and the current odd one
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            cur_sums[c] = {1'b0, r_left[c]} + {1'b0, cur_pix[c]};
        end
    end

    // Even rows store pair sums, odd rows fetch them
    assign slot   = AW'(r_col >> 1);
    assign mem_wr = in_acc && r_col[0] && !r_row[0];
    assign mem_rd = in_acc && r_col[0] && r_row[0];

    // Size registers, position counters and the held left pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= CFG_RESET;
            r_half_height <= CFG_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_left        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_HALF_WIDTH:  r_half_width  <= i_cfg_data;
                REG_HALF_HEIGHT: r_half_height <= i_cfg_data;
                default:         r_half_width  <= r_half_width;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (in_acc) begin
            if (!r_col[0]) begin
                r_left <= cur_pix;
            end
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    // Hold the new pair sums while the line store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= mem_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_s1_sums  <= cur_sums;
            r_s1_final <= col_end && row_end;
        end
    end

    rmd_line_mem #(
        .DEPTH (MAX_HALF_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (slot),
        .i_wr_data (cur_sums),
        .i_rd_en   (mem_rd),
        .i_rd_addr (slot),
        .o_rd_data (prev_sums)
    );

    // Add the vertical pair and drop two bits
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            blk_sum[c]    = {1'b0, r_s1_sums[c]} + {1'b0, prev_sums[c]};
            res_pix.mip[c] = blk_sum[c][SUM_W:2];
        end
        res_pix.final_pixel = r_s1_final;
    end

    rmd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_vld),
        .i_push_data (res_pix),
        .o_level     (buf_level),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (out_pix)
    );

    // Accept only while the buffer can take the result in flight and one more
    assign occupancy = {1'b0, buf_level} + {2'b00, r_s1_vld};
    assign o_ready   = i_rst_n && (occupancy < 3'd2);

    assign o_mip_r       = out_pix.mip[0];
    assign o_mip_g       = out_pix.mip[1];
    assign o_mip_b       = out_pix.mip[2];
    assign o_mip_a       = out_pix.mip[3];
    assign o_final_pixel = out_pix.final_pixel;

endmodule

### hdl/rmd_line_mem.sv
module rmd_line_mem
    import rmd_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  t_pair_sums       i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output t_pair_sums       o_rd_data
);

    t_pair_sums r_mem [DEPTH];
    t_pair_sums r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/rmd_out_buf.sv
module rmd_out_buf
    import rmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_mip_pix    i_push_data,
    output logic [1:0]  o_level,
    output logic        o_valid,
    input  logic        i_ready,
    output t_mip_pix    o_data
);

    t_mip_pix    r_buf [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_level;
    logic        pop;

    assign pop = (r_level != 2'd0) && i_ready;

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_level = r_level;
    assign o_valid = (r_level != 2'd0);
    assign o_data  = r_buf[r_rp];

endmodule

### hdl/rmd_checker.sv
module rmd_checker
    import rmd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             o_ready,
    input  logic             o_valid,
    input  logic             i_ready,
    input  logic [CH_W-1:0]  o_mip_r,
    input  logic [CH_W-1:0]  o_mip_g,
    input  logic [CH_W-1:0]  o_mip_b,
    input  logic [CH_W-1:0]  o_mip_a,
    input  logic             o_final_pixel
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_mip_r) && $stable(o_mip_g) &&
            $stable(o_mip_b) && $stable(o_mip_a) && $stable(o_final_pixel))
        else $error("result changed while stalled");

    // Reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // No result appears without an accepted request before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && o_ready) && !$past(i_valid && o_ready)
            |=> !o_valid)
        else $error("result without a request");

endmodule

bind rgba_mip_downsample_2x2_unit rmd_checker u_rmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_mip_r       (o_mip_r),
    .o_mip_g       (o_mip_g),
    .o_mip_b       (o_mip_b),
    .o_mip_a       (o_mip_a),
    .o_final_pixel (o_final_pixel)
);
